// ----- src/losrc_pkg.sv -----
package losrc_pkg;

  localparam int unsigned ROOT_W = 28;
  localparam int unsigned RAD_W = 2 * ROOT_W;

  // stages before the root unit, then one stage per root bit
  localparam int unsigned PRE_STAGES = 3;
  localparam int unsigned STAGES = PRE_STAGES + ROOT_W;
  localparam int unsigned LOS_STAGE = 11;
  localparam int unsigned LOS_DLY = STAGES - LOS_STAGE;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SATELLITE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EARTH_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ELEVATION = 2'd2;

  localparam logic [12:0] SATELLITE_COUNT_RST = 13'd0;
  localparam logic [23:0] EARTH_RADIUS_RST = 24'd6378137;
  localparam logic [15:0] MIN_ELEVATION_RST = 16'd11380;

  typedef struct packed {
    logic elev;
    logic gate;
    logic d2zero;
  } los_flags_t;

endpackage

// ----- src/losrc_sqrt.sv -----
module losrc_sqrt (
  input  logic                              clk,
  input  logic                              en,
  input  logic [losrc_pkg::RAD_W-1:0]       radicand,
  output logic [losrc_pkg::ROOT_W-1:0]      root
);

  localparam int unsigned W = losrc_pkg::ROOT_W;
  localparam int unsigned NW = losrc_pkg::RAD_W;
  localparam int unsigned TW = NW + 1;

  logic [NW-1:0] rem_q [W];
  logic [W-1:0]  rt_q  [W];

  for (genvar j = 0; j < W; j++) begin : g_bit
    localparam int unsigned K = W - 1 - j;
    logic [NW-1:0] rem_in;
    logic [W-1:0]  rt_in;
    logic [TW-1:0] trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in = radicand;
      assign rt_in  = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign rt_in  = rt_q[j-1];
    end

    assign trial = (TW'(rt_in) << (K + 1)) | (TW'(1) << (2 * K));
    assign ge    = TW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= ge ? rem_in - trial[NW-1:0] : rem_in;
        rt_q[j]  <= ge ? (rt_in | (W'(1) << K)) : rt_in;
      end
    end
  end

  assign root = rt_q[W-1];

endmodule

// ----- src/line_of_sight_range_check_core.sv -----
// channel  direction  handshake             payload
// cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
// in       in         in_valid/in_ready     a_index, a_x..a_z, b_index, b_x..b_z
// out      out        out_valid/out_ready   distance_m, line_of_sight
//
// one pair per cycle sustained while results are accepted
// distance_m comes from the 28 stage square root unit, one result bit per stage
// all stages advance together; an unaccepted result stalls the whole pipe
// rst clears stage valids and restores the register defaults
module line_of_sight_range_check_core #(
  parameter int unsigned NODE_COUNT = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [losrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [losrc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [11:0]                          a_index,
  input  logic signed [26:0]                   a_x,
  input  logic signed [26:0]                   a_y,
  input  logic signed [26:0]                   a_z,
  input  logic [11:0]                          b_index,
  input  logic signed [26:0]                   b_x,
  input  logic signed [26:0]                   b_y,
  input  logic signed [26:0]                   b_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [27:0]                          distance_m,
  output logic                                 line_of_sight
);

  localparam int unsigned STAGES = losrc_pkg::STAGES;
  localparam int unsigned LOS_DLY = losrc_pkg::LOS_DLY;

  logic [12:0] satellite_count;
  logic [23:0] earth_radius_m;
  logic [15:0] min_elevation_sine;
  logic [47:0] r2;
  logic [31:0] m2;

  logic [STAGES:1] vld;
  logic            en;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      satellite_count    <= losrc_pkg::SATELLITE_COUNT_RST;
      earth_radius_m     <= losrc_pkg::EARTH_RADIUS_RST;
      min_elevation_sine <= losrc_pkg::MIN_ELEVATION_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        losrc_pkg::REG_SATELLITE_COUNT: satellite_count <= cfg_data[12:0];
        losrc_pkg::REG_EARTH_RADIUS:    earth_radius_m <= cfg_data;
        losrc_pkg::REG_MIN_ELEVATION:   min_elevation_sine <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2 <= earth_radius_m * earth_radius_m;
    m2 <= min_elevation_sine * min_elevation_sine;
  end

  // pipeline control
  assign en        = !vld[STAGES] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-1:1], in_valid};
    end
  end

  // stage 1: difference vector, node roles
  logic [31:0] sc_lim;
  logic        ga;
  logic        gb;

  assign sc_lim = (32'(satellite_count) > NODE_COUNT) ? NODE_COUNT : 32'(satellite_count);
  assign ga     = 32'(a_index) >= sc_lim;
  assign gb     = 32'(b_index) >= sc_lim;

  logic signed [27:0] s1_d [3];
  logic signed [26:0] s1_q [3];
  logic               s1_elev;
  logic               s1_flip;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d[0] <= 28'(b_x) - 28'(a_x);
      s1_d[1] <= 28'(b_y) - 28'(a_y);
      s1_d[2] <= 28'(b_z) - 28'(a_z);
      s1_q[0] <= (gb && !ga) ? b_x : a_x;
      s1_q[1] <= (gb && !ga) ? b_y : a_y;
      s1_q[2] <= (gb && !ga) ? b_z : a_z;
      s1_elev <= ga != gb;
      s1_flip <= ga && !gb;
    end
  end

  // stage 2: component products
  logic signed [55:0] s2_dd [3];
  logic signed [53:0] s2_qq [3];
  logic signed [54:0] s2_qd [3];
  logic               s2_elev;
  logic               s2_flip;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_dd[i] <= s1_d[i] * s1_d[i];
        s2_qq[i] <= s1_q[i] * s1_q[i];
        s2_qd[i] <= s1_q[i] * s1_d[i];
      end
      s2_elev <= s1_elev;
      s2_flip <= s1_flip;
    end
  end

  // stage 3: squared lengths and dot product
  logic [55:0]        s3_d2;
  logic [53:0]        s3_q2;
  logic signed [55:0] s3_t;
  logic               s3_elev;
  logic               s3_flip;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d2   <= $unsigned(s2_dd[0]) + $unsigned(s2_dd[1]) + $unsigned(s2_dd[2]);
      s3_q2   <= $unsigned(s2_qq[0]) + $unsigned(s2_qq[1]) + $unsigned(s2_qq[2]);
      s3_t    <= s2_qd[0] + s2_qd[1] + s2_qd[2];
      s3_elev <= s2_elev;
      s3_flip <= s2_flip;
    end
  end

  // stage 4: signed projection, test operands
  logic        t_pos;
  logic        t_neg;
  logic        v_pos;
  logic        v_neg;
  logic [54:0] t_abs;
  logic        lt;
  logic [53:0] x_val;
  losrc_pkg::los_flags_t flags4;

  assign t_neg = s3_t[55];
  assign t_pos = !s3_t[55] && (s3_t != '0);
  assign v_pos = s3_flip ? t_pos : t_neg;
  assign v_neg = s3_flip ? t_neg : t_pos;
  assign t_abs = t_neg ? 55'(-s3_t) : 55'(s3_t);
  assign lt    = {1'b0, t_abs} < s3_d2;

  always_comb begin
    if (s3_elev) begin
      x_val = s3_q2;
    end else if (s3_q2 > 54'(r2)) begin
      x_val = s3_q2 - 54'(r2);
    end else begin
      x_val = '0;
    end
    flags4.elev   = s3_elev;
    flags4.gate   = s3_elev ? ((s3_q2 != '0) && !v_neg) : (v_pos && lt);
    flags4.d2zero = s3_d2 == '0;
  end

  logic [54:0] s4_absv;
  logic [55:0] s4_d2;
  logic [53:0] s4_x;
  losrc_pkg::los_flags_t s4_f;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_absv <= t_abs;
      s4_d2   <= s3_d2;
      s4_x    <= x_val;
      s4_f    <= flags4;
    end
  end

  // stage 5: partial products of v^2 and x*d2
  logic [55:0] s5_vll;
  logic [54:0] s5_vlh;
  logic [53:0] s5_vhh;
  logic [55:0] s5_pll;
  logic [55:0] s5_plh;
  logic [53:0] s5_phl;
  logic [53:0] s5_phh;
  losrc_pkg::los_flags_t s5_f;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_vll <= s4_absv[27:0] * s4_absv[27:0];
      s5_vlh <= s4_absv[27:0] * s4_absv[54:28];
      s5_vhh <= s4_absv[54:28] * s4_absv[54:28];
      s5_pll <= s4_x[27:0] * s4_d2[27:0];
      s5_plh <= s4_x[27:0] * s4_d2[55:28];
      s5_phl <= s4_x[53:28] * s4_d2[27:0];
      s5_phh <= s4_x[53:28] * s4_d2[55:28];
      s5_f   <= s4_f;
    end
  end

  // stage 6: fold cross terms
  logic [109:0] s6_vcat;
  logic [55:0]  s6_vmid;
  logic [109:0] s6_pcat;
  logic [56:0]  s6_pmid;
  losrc_pkg::los_flags_t s6_f;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_vcat <= {s5_vhh, s5_vll};
      s6_vmid <= {s5_vlh, 1'b0};
      s6_pcat <= {s5_phh, s5_pll};
      s6_pmid <= 57'(s5_plh) + 57'(s5_phl);
      s6_f    <= s5_f;
    end
  end

  // stage 7: full products
  logic [109:0] s7_v2;
  logic [109:0] s7_p;
  losrc_pkg::los_flags_t s7_f;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_v2 <= s6_vcat + 110'({s6_vmid, 28'd0});
      s7_p  <= s6_pcat + 110'({s6_pmid, 28'd0});
      s7_f  <= s6_f;
    end
  end

  // stage 8: scale by mask square, or by 2^32 for the occlusion test
  logic [32:0]  mval;
  logic [111:0] p_ext;

  assign mval  = s7_f.elev ? {1'b0, m2} : {1'b1, 32'd0};
  assign p_ext = {2'b00, s7_p};

  logic [60:0]  s8_pm [4];
  logic [109:0] s8_v2;
  losrc_pkg::los_flags_t s8_f;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        s8_pm[k] <= p_ext[28*k +: 28] * mval;
      end
      s8_v2 <= s7_v2;
      s8_f  <= s7_f;
    end
  end

  // stage 9
  logic [116:0] s9_e;
  logic [116:0] s9_o;
  logic [109:0] s9_v2;
  losrc_pkg::los_flags_t s9_f;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_e  <= 117'(s8_pm[0]) + {s8_pm[2], 56'd0};
      s9_o  <= 117'(s8_pm[1]) + {s8_pm[3], 56'd0};
      s9_v2 <= s8_v2;
      s9_f  <= s8_f;
    end
  end

  // stage 10
  logic [144:0] s10_r;
  logic [109:0] s10_v2;
  losrc_pkg::los_flags_t s10_f;

  always_ff @(posedge clk) begin
    if (en) begin
      s10_r  <= 145'(s9_e) + {s9_o, 28'd0};
      s10_v2 <= s9_v2;
      s10_f  <= s9_f;
    end
  end

  // stage 11: final compare
  logic cmp;
  logic los;

  assign cmp = {3'b000, s10_v2, 32'd0} >= s10_r;
  assign los = !s10_f.d2zero &&
               (s10_f.elev ? (s10_f.gate && cmp) : !(s10_f.gate && cmp));

  logic s11_los;
  logic los_dly [LOS_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      s11_los    <= los;
      los_dly[0] <= s11_los;
      for (int i = 1; i < LOS_DLY; i++) begin
        los_dly[i] <= los_dly[i-1];
      end
    end
  end

  assign line_of_sight = los_dly[LOS_DLY-1];

  losrc_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (s3_d2),
    .root     (distance_m)
  );

endmodule

// ----- sim/tb_line_of_sight_range_check_core.sv -----
`timescale 1ns / 100ps

module tb_line_of_sight_range_check_core;

  localparam logic [losrc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = losrc_pkg::STAGES + 10;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam longint SAT_ORBIT_M = 7000000;
  localparam longint GROUND_M = 6371000;

  typedef struct packed {
    logic [11:0]        a_index;
    logic signed [26:0] a_x;
    logic signed [26:0] a_y;
    logic signed [26:0] a_z;
    logic [11:0]        b_index;
    logic signed [26:0] b_x;
    logic signed [26:0] b_y;
    logic signed [26:0] b_z;
  } node_pair_t;

  typedef struct packed {
    logic [27:0] distance_m;
    logic        line_of_sight;
  } link_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [losrc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [losrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [11:0] a_index = '0;
  logic signed [26:0] a_x = '0;
  logic signed [26:0] a_y = '0;
  logic signed [26:0] a_z = '0;
  logic [11:0] b_index = '0;
  logic signed [26:0] b_x = '0;
  logic signed [26:0] b_y = '0;
  logic signed [26:0] b_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [27:0] distance_m;
  logic line_of_sight;

  // register copies
  logic [12:0] sat_count = losrc_pkg::SATELLITE_COUNT_RST;
  logic [23:0] radius_m = losrc_pkg::EARTH_RADIUS_RST;
  logic [15:0] elev_sine = losrc_pkg::MIN_ELEVATION_RST;

  node_pair_t pending_pairs[$];
  link_t expected_links[$];
  node_pair_t shown_pair;
  logic gap_free = 1'b0;
  logic hold_trigger = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int errors = 0;

  line_of_sight_range_check_core dut (.*);

  always #6 clk = ~clk;

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic elevation_ok(longint gx, longint gy, longint gz,
                                        longint sx, longint sy, longint sz);
    longint lx, ly, lz, g2, l2, dot;
    logic [191:0] lhs, rhs;
    lx = sx - gx;
    ly = sy - gy;
    lz = sz - gz;
    g2 = gx * gx + gy * gy + gz * gz;
    l2 = lx * lx + ly * ly + lz * lz;
    dot = lx * gx + ly * gy + lz * gz;
    if (g2 == 0 || l2 == 0 || dot < 0) return 1'b0;
    lhs = (192'(dot) * 192'(dot)) << 32;
    rhs = 192'(l2) * 192'(g2) * 192'(64'(elev_sine) * 64'(elev_sine));
    return lhs >= rhs;
  endfunction

  function automatic logic earth_blocks(longint ax, longint ay, longint az,
                                        longint dx, longint dy, longint dz,
                                        longint d2);
    longint p, a2, r2;
    logic [191:0] lhs, rhs;
    p = -(ax * dx + ay * dy + az * dz);
    a2 = ax * ax + ay * ay + az * az;
    r2 = longint'(radius_m) * longint'(radius_m);
    if (p <= 0 || p >= d2) return 1'b0;
    if (a2 <= r2) return 1'b1;
    lhs = 192'(a2 - r2) * 192'(d2);
    rhs = 192'(p) * 192'(p);
    return lhs <= rhs;
  endfunction

  function automatic link_t predict_link(node_pair_t p);
    longint dx, dy, dz, d2;
    logic [12:0] sc;
    logic ga, gb;
    link_t r;
    dx = longint'(p.b_x) - longint'(p.a_x);
    dy = longint'(p.b_y) - longint'(p.a_y);
    dz = longint'(p.b_z) - longint'(p.a_z);
    d2 = dx * dx + dy * dy + dz * dz;
    sc = (sat_count > 13'd4096) ? 13'd4096 : sat_count;
    ga = {1'b0, p.a_index} >= sc;
    gb = {1'b0, p.b_index} >= sc;
    r.distance_m = 28'(floor_sqrt(64'(d2)));
    if (d2 == 0)
      r.line_of_sight = 1'b0;
    else if (ga != gb)
      r.line_of_sight = ga ? elevation_ok(p.a_x, p.a_y, p.a_z, p.b_x, p.b_y, p.b_z)
                           : elevation_ok(p.b_x, p.b_y, p.b_z, p.a_x, p.a_y, p.a_z);
    else
      r.line_of_sight = !earth_blocks(p.a_x, p.a_y, p.a_z, dx, dy, dz, d2);
    return r;
  endfunction

  function automatic void add_pair(node_pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  // driver
  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        expected_links.insert(expected_links.size(), predict_link(shown_pair));
        offer = 1'b0;
      end
      if (!offer && pending_pairs.size() > 0 &&
          (gap_free || $urandom_range(99) >= 37)) begin
        shown_pair = pending_pairs.pop_front();
        a_index <= shown_pair.a_index;
        a_x <= shown_pair.a_x;
        a_y <= shown_pair.a_y;
        a_z <= shown_pair.a_z;
        b_index <= shown_pair.b_index;
        b_x <= shown_pair.b_x;
        b_y <= shown_pair.b_y;
        b_z <= shown_pair.b_z;
        offer = 1'b1;
      end
      in_valid <= offer;
    end
  end

  // monitor, receiver stalls and watchdog
  always @(posedge clk) begin
    link_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_links.size() == 0) begin
          $error("result with no expectation: distance_m %0d line_of_sight %0b",
                 distance_m, line_of_sight);
          errors++;
        end else begin
          want = expected_links.pop_front();
          if (distance_m !== want.distance_m) begin
            $error("distance_m expected %0d actual %0d", want.distance_m, distance_m);
            errors++;
          end
          if (line_of_sight !== want.line_of_sight) begin
            $error("line_of_sight expected %0b actual %0b",
                   want.line_of_sight, line_of_sight);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
      if (hold_trigger && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= gap_free || $urandom_range(99) >= 37;
      end
    end
  end

  task automatic write_reg(logic [losrc_pkg::CFG_IDX_W-1:0] idx,
                           logic [losrc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      losrc_pkg::REG_SATELLITE_COUNT: sat_count = val[12:0];
      losrc_pkg::REG_EARTH_RADIUS:    radius_m = val;
      losrc_pkg::REG_MIN_ELEVATION:   elev_sine = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_pairs.size() > 0 || in_valid || expected_links.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic longint rand_signed(longint span);
    return longint'($urandom_range(32'(2 * span))) - span;
  endfunction

  // point at a random direction scaled to the given radius
  function automatic node_pair_t place(node_pair_t p, logic side, longint rad);
    longint vx, vy, vz, n;
    do begin
      vx = rand_signed(1000);
      vy = rand_signed(1000);
      vz = rand_signed(1000);
      n = longint'(floor_sqrt(64'(vx * vx + vy * vy + vz * vz)));
    end while (n == 0);
    if (side) begin
      p.b_x = 27'(vx * rad / n);
      p.b_y = 27'(vy * rad / n);
      p.b_z = 27'(vz * rad / n);
    end else begin
      p.a_x = 27'(vx * rad / n);
      p.a_y = 27'(vy * rad / n);
      p.a_z = 27'(vz * rad / n);
    end
    return p;
  endfunction

  function automatic logic [11:0] pick_index(logic ground);
    logic [12:0] sc;
    sc = (sat_count > 13'd4096) ? 13'd4096 : sat_count;
    if (ground && sc < 13'd4096) return 12'($urandom_range(4095, sc));
    if (!ground && sc > 0) return 12'($urandom_range(sc - 1, 0));
    return 12'($urandom);
  endfunction

  function automatic node_pair_t random_pair();
    node_pair_t p;
    int kind;
    logic ga, gb;
    kind = $urandom_range(9);
    p = node_pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if (kind < 7) begin
      ga = $urandom_range(1);
      gb = (kind < 4) ? !ga : $urandom_range(1);
      p.a_index = pick_index(ga);
      p.b_index = pick_index(gb);
      p = place(p, 1'b0, ga ? GROUND_M : SAT_ORBIT_M + rand_signed(3000000));
      p = place(p, 1'b1, gb ? GROUND_M : SAT_ORBIT_M + rand_signed(3000000));
    end else if (kind == 7) begin
      p.b_x = p.a_x;
      p.b_y = p.a_y;
      p.b_z = p.a_z;
      if ($urandom_range(1)) p.b_z = p.a_z + 27'sd1;
    end
    return p;
  endfunction

  task automatic queue_random(int count);
    repeat (count) begin
      @(negedge clk);
      add_pair(random_pair());
    end
  endtask

  task automatic queue_directed();
    localparam logic signed [26:0] CMAX = 27'sh3FFFFFF;
    localparam logic signed [26:0] CMIN = -27'sh4000000;
    // extremes of the coordinate range
    add_pair('{12'd0, CMIN, CMIN, CMIN, 12'd4095, CMAX, CMAX, CMAX});
    add_pair('{12'd4095, CMAX, CMIN, CMAX, 12'd0, CMIN, CMAX, CMIN});
    add_pair('{12'd0, CMAX, 27'sd0, 27'sd0, 12'd1, CMIN, 27'sd0, 27'sd0});
    // coincident endpoints
    add_pair('{12'd5, 27'sd7000000, 27'sd1, -27'sd3, 12'd6,
               27'sd7000000, 27'sd1, -27'sd3});
    add_pair('{12'd0, 27'sd0, 27'sd0, 27'sd0, 12'd0, 27'sd0, 27'sd0, 27'sd0});
    // satellites on either side of the earth, and a grazing pair
    add_pair('{12'd1, 27'sd7000000, 27'sd0, 27'sd0, 12'd2,
               -27'sd7000000, 27'sd0, 27'sd0});
    add_pair('{12'd1, 27'sd7000000, 27'sd6378137, 27'sd0, 12'd2,
               -27'sd7000000, 27'sd6378137, 27'sd0});
    add_pair('{12'd1, 27'sd7000000, 27'sd6378138, 27'sd0, 12'd2,
               -27'sd7000000, 27'sd6378138, 27'sd0});
    // end point inside the sphere
    add_pair('{12'd1, 27'sd100, 27'sd0, 27'sd0, 12'd2,
               27'sd9000000, 27'sd0, 27'sd0});
    // station at the centre and ordinary satellite to ground links
    add_pair('{12'd4000, 27'sd0, 27'sd0, 27'sd0, 12'd3,
               27'sd7000000, 27'sd0, 27'sd0});
    add_pair('{12'd4000, 27'sd6378137, 27'sd0, 27'sd0, 12'd3,
               27'sd7000000, 27'sd0, 27'sd0});
    add_pair('{12'd3, 27'sd0, 27'sd7000000, 27'sd0, 12'd4000,
               27'sd6378137, 27'sd0, 27'sd0});
    add_pair('{12'd3, 27'sd6378137, 27'sd1200000, 27'sd0, 12'd4000,
               27'sd6378137, 27'sd0, 27'sd0});
    add_pair('{12'd3, 27'sd6500000, 27'sd3000000, 27'sd0, 12'd4000,
               27'sd6378137, 27'sd0, 27'sd0});
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    queue_random(8);
    drain();

    write_reg(losrc_pkg::REG_SATELLITE_COUNT, 24'd10);
    write_reg(REG_SPARE, 24'hFFFFFF);
    queue_directed();
    drain();

    write_reg(losrc_pkg::REG_MIN_ELEVATION, 24'd0);
    queue_directed();
    queue_random(60);
    drain();

    write_reg(losrc_pkg::REG_SATELLITE_COUNT, 24'd2000);
    write_reg(losrc_pkg::REG_EARTH_RADIUS, 24'd6378137);
    write_reg(losrc_pkg::REG_MIN_ELEVATION, 24'd11380);
    gap_free = 1'b1;
    queue_random(100);
    drain();
    gap_free = 1'b0;

    write_reg(losrc_pkg::REG_SATELLITE_COUNT, 24'd8191);
    write_reg(losrc_pkg::REG_EARTH_RADIUS, 24'hFFFFFF);
    write_reg(losrc_pkg::REG_MIN_ELEVATION, 24'hFFFF);
    hold_trigger = 1'b1;
    queue_random(80);
    drain();

    write_reg(losrc_pkg::REG_SATELLITE_COUNT, 24'd4096);
    write_reg(losrc_pkg::REG_EARTH_RADIUS, 24'd0);
    write_reg(losrc_pkg::REG_MIN_ELEVATION, 24'd30000);
    queue_random(60);
    drain();

    write_reg(losrc_pkg::REG_SATELLITE_COUNT, 24'd3000);
    write_reg(losrc_pkg::REG_EARTH_RADIUS, 24'd6000000);
    write_reg(losrc_pkg::REG_MIN_ELEVATION, 24'd5000);
    queue_random(110);
    drain();

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
